/* hw/rtl/rgwa_pkg.sv */
// rgwa_pkg: shared types and constants for the regular grammar word acceptor.
// Used by rgwa_seq and regular_grammar_word_acceptor; no dependencies.
`default_nettype none

package rgwa_pkg;

   // Fixed field widths of the command and config beats
   localparam int ACT_W   = 2;
   localparam int FROM_W  = 5;
   localparam int SYM_W   = 5;
   localparam int TO_W    = 5;
   localparam int START_W = 5;

   // Defaults for the top-level parameters and the reset value of the start symbol
   localparam int NT_DEFAULT    = 26;
   localparam int SYM_DEFAULT   = 26;
   localparam int START_RESET   = 18;

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_CHAR  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_WR,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic valid;
      logic accepted;
   } result_type;

endpackage : rgwa_pkg

`default_nettype wire

/* hw/rtl/regular_grammar_word_acceptor.sv */
// regular_grammar_word_acceptor: top level, config register and result register.
// Depends on rgwa_pkg, rgwa_seq (which holds rgwa_ram).
//
// Decides membership of words in a right-linear grammar by stepping the set of
// live nonterminals of its automaton. A command beat is taken when start is high
// and busy is low. action selects: clear the rule store, add one rule
// rule_from -> symbol rule_to (rule_to == NONTERMINALS means a terminal-only
// rule), or feed one word character. Rules out of range are dropped. The rule
// store is a RAM of NONTERMINALS*SYMBOLS rows; after reset and after each clear
// command the block sweeps it, one row per cycle, with busy high until the sweep
// ends. Adding a rule is a read-modify-write of one row: busy for one cycle. A
// character reads one row per nonterminal from the single read port of the
// store, so busy stays high through the scan and the finish step. When
// last_of_word is set, rsp_valid pulses for exactly one cycle with rsp_accepted,
// registered from the finish step. The receiver cannot stall results. The start
// symbol is written on the csr channel (always ready); the user must write it only
// while the block is idle, which the block does not enforce; its reset value is S.
`default_nettype none

module regular_grammar_word_acceptor
   import rgwa_pkg::*;
#(
   parameter int NONTERMINALS = NT_DEFAULT,
   parameter int SYMBOLS      = SYM_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [ACT_W-1:0]   req_action,
   input  wire logic [FROM_W-1:0]  req_rule_from,
   input  wire logic [SYM_W-1:0]   req_symbol,
   input  wire logic [TO_W-1:0]    req_rule_to,
   input  wire logic               req_last_of_word,
   // result channel
   output      logic               rsp_valid,
   output      logic               rsp_accepted,
   // config channel: start symbol
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [START_W-1:0] csr_data
);

   logic [START_W-1:0] start_sym_ff, start_sym_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_accepted_ff, rsp_accepted_in;
   result_type         seq_result;

   // Config register is a plain write; no side effects
   assign csr_ready    = 1'b1;
   assign start_sym_in = (csr_valid && csr_ready) ? csr_data : start_sym_ff;

   // Result beat is registered, giving a one-cycle strobe
   assign rsp_valid_in    = seq_result.valid;
   assign rsp_accepted_in = seq_result.accepted;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_sym_ff <= START_W'(START_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         start_sym_ff <= start_sym_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff <= rsp_accepted_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

   rgwa_seq #(
      .NONTERMINALS (NONTERMINALS),
      .SYMBOLS      (SYMBOLS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .action       (req_action),
      .rule_from    (req_rule_from),
      .symbol       (req_symbol),
      .rule_to      (req_rule_to),
      .last_of_word (req_last_of_word),
      .start_symbol (start_sym_ff),
      .busy         (busy),
      .result       (seq_result)
   );

   // result strobes never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a result beat lands while the engine is idle again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while engine busy");

   // the engine's verdict shows on the ports in the following cycle, unchanged
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      seq_result.valid |=> (rsp_valid && rsp_accepted == $past(seq_result.accepted)))
      else $error("result strobe lost or altered on the way out");

endmodule : regular_grammar_word_acceptor

`default_nettype wire

/* hw/rtl/rgwa_ram.sv */
// rgwa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rgwa_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 676
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule : rgwa_ram

`default_nettype wire

/* hw/rtl/rgwa_seq.sv */
// rgwa_seq: sequencer around the rule store: clear sweep, rule read-modify-write,
// per-character row scan of the live set. Depends on rgwa_pkg and rgwa_ram.
`default_nettype none

module rgwa_seq
   import rgwa_pkg::*;
#(
   parameter int NONTERMINALS = NT_DEFAULT,
   parameter int SYMBOLS      = SYM_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [ACT_W-1:0]   action,
   input  wire logic [FROM_W-1:0]  rule_from,
   input  wire logic [SYM_W-1:0]   symbol,
   input  wire logic [TO_W-1:0]    rule_to,
   input  wire logic               last_of_word,
   input  wire logic [START_W-1:0] start_symbol,
   output      logic               busy,
   output      result_type         result
);

   localparam int ROWS   = NONTERMINALS * SYMBOLS;
   localparam int ADDR_W = $clog2(ROWS);
   localparam int ROW_W  = NONTERMINALS + 1;
   localparam int N_W    = $clog2(NONTERMINALS);
   localparam logic [ADDR_W-1:0] SYM_STEP = ADDR_W'(SYMBOLS);
   localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROWS - 1);
   localparam logic [N_W-1:0]    LAST_NT  = N_W'(NONTERMINALS - 1);

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [N_W-1:0]          idx_ff, idx_in;
   logic [TO_W-1:0]         to_ff, to_in;
   logic                    last_ff, last_in;
   logic                    pend_ff, pend_in;
   logic                    term_ff, term_in;
   logic                    word_start_ff, word_start_in;
   logic [NONTERMINALS-1:0] work_ff, work_in;
   logic [NONTERMINALS-1:0] acc_ff, acc_in;
   logic [NONTERMINALS-1:0] live_ff, live_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [ROW_W-1:0]  ram_wdata, ram_rdata;

   logic                    rule_ok, sym_ok;
   logic [ADDR_W-1:0]       row_addr;
   logic [NONTERMINALS-1:0] init_set, fin_set;
   logic                    fin_term;

   rgwa_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy = (state_ff != ST_IDLE);

   assign sym_ok   = (32'(symbol) < SYMBOLS);
   assign rule_ok  = (32'(rule_from) < NONTERMINALS) && sym_ok &&
                     (32'(rule_to) <= NONTERMINALS);
   assign row_addr = ADDR_W'(rule_from) * SYM_STEP + ADDR_W'(symbol);

   // Live set at word start comes from the start symbol; empty if out of range
   always_comb begin
      if (word_start_ff) begin
         init_set = (32'(start_symbol) < NONTERMINALS) ?
                    (NONTERMINALS'(1) << start_symbol) : '0;
      end else begin
         init_set = live_ff;
      end
   end

   assign fin_set  = acc_ff | (pend_ff ? ram_rdata[NONTERMINALS-1:0] : '0);
   assign fin_term = term_ff | (pend_ff & ram_rdata[NONTERMINALS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         word_start_ff <= 1'b1;
         live_ff       <= '0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         word_start_ff <= word_start_in;
         live_ff       <= live_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      to_ff   <= to_in;
      last_ff <= last_in;
      term_ff <= term_in;
      work_ff <= work_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      to_in         = to_ff;
      last_in       = last_ff;
      pend_in       = 1'b0;
      term_in       = term_ff;
      word_start_in = word_start_ff;
      work_in       = work_ff;
      acc_in        = acc_ff;
      live_in       = live_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = '0;
      ram_raddr     = addr_ff;
      result        = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (action_type'(action))
                  ACT_CLEAR: begin
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  ACT_ADD: begin
                     if (rule_ok) begin
                        ram_raddr = row_addr;
                        addr_in   = row_addr;
                        to_in     = rule_to;
                        state_in  = ST_ADD_WR;
                     end
                  end
                  ACT_CHAR: begin
                     work_in       = sym_ok ? init_set : '0;
                     addr_in       = ADDR_W'(symbol);
                     idx_in        = '0;
                     acc_in        = '0;
                     term_in       = 1'b0;
                     last_in       = last_of_word;
                     word_start_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_WR: begin
            // row read last cycle; OR in the new rule bit
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (ROW_W'(1) << to_ff);
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            pend_in = work_ff[idx_ff];
            addr_in = addr_ff + SYM_STEP;
            idx_in  = idx_ff + N_W'(1);
            acc_in  = fin_set;
            term_in = fin_term;
            if (idx_ff == LAST_NT) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            live_in         = fin_set;
            word_start_in   = last_ff;
            result.valid    = last_ff;
            result.accepted = fin_term;
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // store is written only by the clear sweep or the rule write-back
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_ADD_WR))
      else $error("rule store written outside clear or rule update");

   // finish always follows the final scan step
   a_finish_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ($past(state_ff) == ST_SCAN && $past(idx_ff) == LAST_NT))
      else $error("finish reached without a complete scan");

   // an accepted character starts a scan at index zero
   a_char_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && action == ACT_CHAR)
      |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("character beat did not start a scan");

   // a result leaves only from the finish step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (state_ff == ST_FINISH && last_ff))
      else $error("result outside finish of a last character");

endmodule : rgwa_seq

`default_nettype wire

/* sim/testbench.sv */
// testbench: self-checking bench for regular_grammar_word_acceptor.
// Depends on rgwa_pkg and the block's RTL only. Holds its own automaton predictor and
// checks every accept beat against it.
`timescale 1ns / 1ps

module testbench;
   import rgwa_pkg::*;

   // Unused action code; the block must drop it without a result
   localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
   // rule_to value that marks a terminal-only production
   localparam logic [TO_W-1:0]  TO_TERMINAL = TO_W'(NT_DEFAULT);
   localparam int ROWS       = NT_DEFAULT * SYM_DEFAULT;
   localparam int SETTLE     = NT_DEFAULT + 8;  // covers a character still in flight
   localparam int PHASES     = 8;
   localparam int PHASE_BEATS = 70;

   // A few names for the directed script
   localparam logic [4:0] NT_A = 5'd0, NT_S = 5'd18, NT_Z = 5'd25, NT_BAD = 5'd31;
   localparam logic [4:0] CH_A = 5'd0, CH_B = 5'd1, CH_C = 5'd2, CH_D = 5'd3;
   localparam logic [4:0] CH_Z = 5'd25, CH_BAD = 5'd31;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [ACT_W-1:0]   req_action;
   logic [FROM_W-1:0]  req_rule_from;
   logic [SYM_W-1:0]   req_symbol;
   logic [TO_W-1:0]    req_rule_to;
   logic               req_last_of_word;
   logic               rsp_valid;
   logic               rsp_accepted;
   logic               csr_valid;
   logic               csr_ready;
   logic [START_W-1:0] csr_data;

   regular_grammar_word_acceptor u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_rule_from    (req_rule_from),
      .req_symbol       (req_symbol),
      .req_rule_to      (req_rule_to),
      .req_last_of_word (req_last_of_word),
      .rsp_valid        (rsp_valid),
      .rsp_accepted     (rsp_accepted),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   // Predictor state: transition rows, live nonterminal set, word bookkeeping
   logic [NT_DEFAULT:0]   grammar_rows [ROWS];
   logic [NT_DEFAULT-1:0] live_nts;
   bit                    ended_on_terminal;
   bit                    fresh_word;
   logic [START_W-1:0]    start_nt;

   bit          verdict_q [$];     // accept bits still owed by the block
   bit          expected_verdict;
   int unsigned error_count;
   int unsigned beats_sent;
   int unsigned words_checked;
   int unsigned words_accepted;
   bit          gaps_on;

   // Random grammar material for the current phase
   logic [4:0] nt_pool [5];
   logic [4:0] letters [4];

   // Directed script: one row per command beat. A row with typed set carries
   // the accept bit that is obvious by inspection; others use the predictor.
   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic [4:0]       nt_from;
      logic [4:0]       sym;
      logic [4:0]       nt_to;
      logic             word_end;
      logic             typed;
      logic             verdict;
   } script_row_type;

   localparam int SCRIPT_LEN = 26;
   script_row_type script [SCRIPT_LEN] = '{
      '{ACT_CHAR,   NT_A,   CH_A,   NT_A,        1'b1, 1'b1, 1'b0}, // empty store
      '{ACT_ADD,    NT_S,   CH_A,   TO_TERMINAL, 1'b0, 1'b0, 1'b0}, // S -> a
      '{ACT_CHAR,   NT_A,   CH_A,   NT_A,        1'b1, 1'b1, 1'b1},
      '{ACT_ADD,    NT_S,   CH_B,   NT_A,        1'b0, 1'b0, 1'b0}, // S -> bA
      '{ACT_ADD,    NT_A,   CH_C,   TO_TERMINAL, 1'b1, 1'b0, 1'b0}, // A -> c
      '{ACT_CHAR,   NT_BAD, CH_B,   NT_BAD,      1'b0, 1'b0, 1'b0},
      '{ACT_CHAR,   NT_A,   CH_C,   NT_A,        1'b1, 1'b0, 1'b0}, // "bc"
      '{ACT_UNUSED, NT_BAD, CH_BAD, NT_BAD,      1'b1, 1'b0, 1'b0}, // dropped
      '{ACT_ADD,    NT_BAD, CH_A,   NT_A,        1'b0, 1'b0, 1'b0}, // from out of range
      '{ACT_ADD,    NT_S,   CH_BAD, TO_TERMINAL, 1'b0, 1'b0, 1'b0}, // symbol out of range
      '{ACT_ADD,    NT_S,   CH_C,   5'd27,       1'b0, 1'b0, 1'b0}, // rule_to past marker
      '{ACT_ADD,    NT_S,   CH_A,   TO_TERMINAL, 1'b0, 1'b0, 1'b0}, // duplicate
      '{ACT_CHAR,   NT_A,   CH_BAD, NT_A,        1'b1, 1'b1, 1'b0}, // bad character
      '{ACT_CHAR,   NT_A,   CH_C,   NT_A,        1'b1, 1'b0, 1'b0}, // no S -> c
      '{ACT_CHAR,   NT_A,   CH_B,   NT_A,        1'b0, 1'b0, 1'b0},
      '{ACT_CHAR,   NT_A,   CH_Z,   NT_A,        1'b0, 1'b0, 1'b0}, // set dies
      '{ACT_CHAR,   NT_A,   CH_C,   NT_A,        1'b1, 1'b1, 1'b0}, // stays dead
      '{ACT_CHAR,   NT_A,   CH_B,   NT_A,        1'b0, 1'b0, 1'b0},
      '{ACT_ADD,    NT_A,   CH_D,   TO_TERMINAL, 1'b0, 1'b0, 1'b0}, // A -> d mid-word
      '{ACT_CHAR,   NT_A,   CH_D,   NT_A,        1'b1, 1'b0, 1'b0},
      '{ACT_ADD,    NT_S,   CH_Z,   NT_Z,        1'b0, 1'b0, 1'b0}, // S -> zZ
      '{ACT_ADD,    NT_Z,   CH_Z,   TO_TERMINAL, 1'b0, 1'b0, 1'b0}, // Z -> z
      '{ACT_CHAR,   NT_A,   CH_Z,   NT_A,        1'b0, 1'b0, 1'b0},
      '{ACT_CHAR,   NT_A,   CH_Z,   NT_A,        1'b1, 1'b0, 1'b0}, // "zz"
      '{ACT_CHAR,   NT_A,   CH_B,   NT_A,        1'b0, 1'b0, 1'b0},
      '{ACT_CLEAR,  NT_A,   CH_A,   NT_A,        1'b0, 1'b0, 1'b0}  // clear mid-word
   };
   // after the mid-word clear, "b?" ends on an empty store
   script_row_type script_tail = '{ACT_CHAR, NT_A, CH_C, NT_A, 1'b1, 1'b1, 1'b0};

   // Automaton predictor: applies one command beat, returns 1 when the beat
   // ends a word, with the accept bit in verdict.
   function automatic bit grammar_step(input logic [ACT_W-1:0] act,
         input logic [4:0] nt_from, input logic [4:0] sym, input logic [4:0] nt_to,
         input logic word_end, output bit verdict);
      logic [NT_DEFAULT-1:0] next_live;
      logic [NT_DEFAULT:0]   row;
      bit                    hit_terminal;
      verdict = 1'b0;
      if (act == ACT_CLEAR) begin
         foreach (grammar_rows[i]) grammar_rows[i] = '0;
         return 1'b0;
      end
      if (act == ACT_ADD) begin
         if (nt_from < NT_DEFAULT && sym < SYM_DEFAULT && nt_to <= NT_DEFAULT)
            grammar_rows[int'(nt_from) * SYM_DEFAULT + int'(sym)][nt_to] = 1'b1;
         return 1'b0;
      end
      if (act != ACT_CHAR)
         return 1'b0;
      if (fresh_word) begin
         live_nts = '0;
         if (start_nt < NT_DEFAULT)
            live_nts[start_nt] = 1'b1;
         ended_on_terminal = 1'b0;
         fresh_word = 1'b0;
      end
      // out-of-range characters match nothing, so the set dies
      next_live = '0;
      hit_terminal = 1'b0;
      if (sym < SYM_DEFAULT) begin
         for (int n = 0; n < NT_DEFAULT; n++) begin
            if (live_nts[n]) begin
               row = grammar_rows[n * SYM_DEFAULT + int'(sym)];
               next_live |= row[NT_DEFAULT-1:0];
               hit_terminal |= row[NT_DEFAULT];
            end
         end
      end
      live_nts = next_live;
      ended_on_terminal = hit_terminal;
      if (!word_end)
         return 1'b0;
      fresh_word = 1'b1;
      verdict = ended_on_terminal;
      return 1'b1;
   endfunction

   // Presents one command beat and holds it until busy is low at an edge.
   // start is left high on return, unless a random gap lowered it, so the caller
   // can chain the next beat in the same step; anyone who does not chain must lower it at once.
   task automatic issue(input logic [ACT_W-1:0] act, input logic [4:0] nt_from,
         input logic [4:0] sym, input logic [4:0] nt_to, input logic word_end,
         input bit typed, input bit typed_verdict);
      bit produced;
      bit verdict;
      req_action       <= act;
      req_rule_from    <= nt_from;
      req_symbol       <= sym;
      req_rule_to      <= nt_to;
      req_last_of_word <= word_end;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      produced = grammar_step(act, nt_from, sym, nt_to, word_end, verdict);
      if (produced)
         verdict_q = {verdict_q, (typed ? typed_verdict : verdict)};
      if (act != ACT_UNUSED)
         beats_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Waits for the block to drain, then writes the start symbol register.
   task automatic write_start_symbol(input logic [START_W-1:0] value);
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (busy) @(posedge clock);   // a clear sweep may still be running
      if (gaps_on)
         repeat ($urandom_range(1, 15)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      start_nt = value;
      csr_valid <= 1'b0;
   endtask

   // Adds a rule over the phase's nonterminals and letters; now and then one
   // field is redrawn over 0..31, so it may fall out of range and be dropped.
   task automatic add_random_rule();
      logic [4:0] nt_from;
      logic [4:0] sym;
      logic [4:0] nt_to;
      nt_from = nt_pool[$urandom_range(0, 4)];
      sym     = letters[$urandom_range(0, 3)];
      nt_to   = ($urandom_range(0, 2) == 0) ? TO_TERMINAL : nt_pool[$urandom_range(0, 4)];
      case ($urandom_range(0, 11))
         0: nt_from = 5'($urandom_range(0, 31));
         1: sym     = 5'($urandom_range(0, 31));
         2: nt_to   = 5'($urandom_range(0, 31));
         default: ;
      endcase
      issue(ACT_ADD, nt_from, sym, nt_to, 1'($urandom), 1'b0, 1'b0);
   endtask

   // One word over the phase's letters, with the odd stray character and
   // rule edits, clears and dropped codes mixed in between characters.
   task automatic send_word();
      int         len;
      logic [4:0] ch;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 39))
            0: issue(ACT_UNUSED, 5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom),
                     1'b0, 1'b0);
            1, 2: add_random_rule();
            3: if ($urandom_range(0, 3) == 0)
                  issue(ACT_CLEAR, 5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom),
                        1'b0, 1'b0);
            default: ;
         endcase
         ch = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                           : letters[$urandom_range(0, 3)];
         issue(ACT_CHAR, 5'($urandom), ch, 5'($urandom), i == len - 1, 1'b0, 1'b0);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Accept checker: the block cannot be stalled, so every strobe is a beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            $error("accepted: no result expected, got %0b", rsp_accepted);
            error_count++;
         end else begin
            expected_verdict = verdict_q.pop_front();
            words_checked++;
            if (rsp_accepted) words_accepted++;
            if (rsp_accepted !== expected_verdict) begin
               $error("accepted: expected %0b, got %0b", expected_verdict, rsp_accepted);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [START_W-1:0] start_values [PHASES];
      int unsigned        phase_goal;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_action       <= ACT_CLEAR;
      req_rule_from    <= '0;
      req_symbol       <= '0;
      req_rule_to      <= '0;
      req_last_of_word <= 1'b0;
      csr_valid        <= 1'b0;
      csr_data         <= '0;

      foreach (grammar_rows[i]) grammar_rows[i] = '0;
      live_nts          = '0;
      ended_on_terminal = 1'b0;
      fresh_word        = 1'b1;
      start_nt          = START_W'(START_RESET);
      error_count       = 0;
      beats_sent        = 0;
      words_checked     = 0;
      words_accepted    = 0;
      gaps_on           = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, on the reset start symbol S
      foreach (script[i]) begin
         gaps_on = $urandom_range(0, 1);
         issue(script[i].act, script[i].nt_from, script[i].sym, script[i].nt_to,
               script[i].word_end, script[i].typed, script[i].verdict);
      end
      issue(script_tail.act, script_tail.nt_from, script_tail.sym, script_tail.nt_to,
            script_tail.word_end, script_tail.typed, script_tail.verdict);

      // Random phases. Start symbols cover both ends of the alphabet and the
      // codes past Z, which must reject every word.
      start_values = '{5'd0, 5'd25, 5'd31, 5'd26, 5'd18,
                       5'($urandom_range(0, 25)), 5'($urandom_range(0, 31)), 5'd7};
      for (int p = 0; p < PHASES; p++) begin
         write_start_symbol(start_values[p]);
         nt_pool[0] = (start_values[p] < NT_DEFAULT) ? start_values[p]
                                                     : 5'($urandom_range(0, 25));
         for (int k = 1; k < 5; k++)
            nt_pool[k] = 5'($urandom_range(0, 25));
         // small alphabets make accepted words common
         letters[0] = ($urandom_range(0, 3) == 0) ? 5'd25 : 5'($urandom_range(0, 25));
         for (int k = 1; k < 4; k++)
            letters[k] = (k <= $urandom_range(1, 3)) ? 5'($urandom_range(0, 25)) : letters[0];
         issue(ACT_CLEAR, 5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom),
               1'b0, 1'b0);
         repeat ($urandom_range(8, 20)) add_random_rule();
         phase_goal = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_goal) begin
            // last phase runs with no idling at all
            gaps_on = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
            send_word();
         end
      end

      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("summary: %0d command beats, %0d words checked (%0d accepted)",
               beats_sent, words_checked, words_accepted);
      $display("summary: %0d start symbol settings incl. out-of-range codes", PHASES);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
